@@ rtl/cpt_pkg.sv @@
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared types, constants and helper functions of the convex polygon point
// test block.
// ----------------------------------------------------------------------------
package cpt_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int ADDR_W       = $clog2(MAX_VERTICES);
	localparam int IDX_W        = 10;
	localparam int COORD_W      = 31;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int PROD_W       = 2 * DIFF_W;
	localparam int VC_W         = 11;
	localparam int TALLY_W      = 32;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 32;
	localparam int TRI_STEPS    = 6;
	localparam int STEP_W       = $clog2(TRI_STEPS);
	localparam int MIN_VERTICES = 3;

	localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_QUERY = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VERTEX_COUNT  = 1'b0,
		REG_NEEDED_INSIDE = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		SG_ZERO = 2'b00,
		SG_POS  = 2'b01,
		SG_NEG  = 2'b10
	} sign_t;

	typedef logic [ADDR_W-1:0]         addr_t;
	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} vertex_t;

	typedef struct packed {
		logic    we;
		addr_t   addr;
		vertex_t data;
	} mem_wr_t;

	typedef struct packed {
		logic  start;
		diff_t ax;
		diff_t ay;
		diff_t bx;
		diff_t by;
	} xreq_t;

	typedef struct packed {
		logic  done;
		sign_t sgn;
	} xrsp_t;

	function automatic diff_t coord_diff(coord_t a, coord_t b);
		return DIFF_W'(a) - DIFF_W'(b);
	endfunction

	function automatic sign_t sign_flip(sign_t s);
		sign_t r;
		case (s)
			SG_POS:  r = SG_NEG;
			SG_NEG:  r = SG_POS;
			default: r = SG_ZERO;
		endcase
		return r;
	endfunction

	// True when the product of two signs is not negative.
	function automatic logic sign_agree(sign_t a, sign_t b);
		return (a == SG_ZERO) || (b == SG_ZERO) || (a == b);
	endfunction

endpackage

@@ rtl/cpt_stream_if.sv @@
// ----------------------------------------------------------------------------
// cpt_in_if / cpt_out_if
// Valid/ready channels that carry the input words and the result words.
// ----------------------------------------------------------------------------
interface cpt_in_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   op;
	logic [cpt_pkg::IDX_W-1:0]    vertex_index;
	logic signed [cpt_pkg::COORD_W-1:0] coord_x;
	logic signed [cpt_pkg::COORD_W-1:0] coord_y;

	modport source (output valid, op, vertex_index, coord_x, coord_y, input ready);
	modport sink (input valid, op, vertex_index, coord_x, coord_y, output ready);
endinterface

interface cpt_out_if;
	logic                        valid;
	logic                        ready;
	logic                        is_inside;
	logic [cpt_pkg::TALLY_W-1:0] inside_count;
	logic                        enough;

	modport source (output valid, is_inside, inside_count, enough, input ready);
	modport sink (input valid, is_inside, inside_count, enough, output ready);
endinterface

@@ rtl/cpt_vertex_mem.sv @@
// ----------------------------------------------------------------------------
// cpt_vertex_mem
// Vertex table: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cpt_vertex_mem (
	input  logic                     clk,
	input  cpt_pkg::mem_wr_t         wr,
	input  cpt_pkg::addr_t           raddr,
	output cpt_pkg::vertex_t         rdata
);

	cpt_pkg::vertex_t mem [cpt_pkg::MAX_VERTICES];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/cpt_cross_unit.sv @@
// ----------------------------------------------------------------------------
// cpt_cross_unit
// Sign of ax*by - bx*ay, computed with one shared multiplier that forms the
// two products one after the other; the sign is presented with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module cpt_cross_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  cpt_pkg::xreq_t req,
	output cpt_pkg::xrsp_t rsp
);

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_MULP = 4'b0010,
		PH_MULQ = 4'b0100,
		PH_CMP  = 4'b1000
	} phase_t;

	phase_t                              phase_q;
	cpt_pkg::diff_t                      ax_q, ay_q, bx_q, by_q;
	cpt_pkg::diff_t                      mul_a, mul_b;
	logic signed [cpt_pkg::PROD_W-1:0]   prod;
	logic signed [cpt_pkg::PROD_W-1:0]   p_q, q_q;
	logic                                done_q;
	cpt_pkg::sign_t                      sgn_q;

	always_comb begin
		if (phase_q == PH_MULP) begin
			mul_a = ax_q;
			mul_b = by_q;
		end else begin
			mul_a = bx_q;
			mul_b = ay_q;
		end
		prod = cpt_pkg::PROD_W'(mul_a) * cpt_pkg::PROD_W'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (phase_q == PH_CMP);
			case (phase_q)
				PH_IDLE: begin
					if (req.start) begin
						phase_q <= PH_MULP;
					end
				end
				PH_MULP: phase_q <= PH_MULQ;
				PH_MULQ: phase_q <= PH_CMP;
				PH_CMP: begin
					phase_q <= PH_IDLE;
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == PH_IDLE && req.start) begin
			ax_q <= req.ax;
			ay_q <= req.ay;
			bx_q <= req.bx;
			by_q <= req.by;
		end
		if (phase_q == PH_MULP) begin
			p_q <= prod;
		end
		if (phase_q == PH_MULQ) begin
			q_q <= prod;
		end
		if (phase_q == PH_CMP) begin
			if (p_q > q_q) begin
				sgn_q <= cpt_pkg::SG_POS;
			end else if (p_q < q_q) begin
				sgn_q <= cpt_pkg::SG_NEG;
			end else begin
				sgn_q <= cpt_pkg::SG_ZERO;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.sgn  = sgn_q;

endmodule

@@ rtl/cpt_ctrl.sv @@
// ----------------------------------------------------------------------------
// cpt_ctrl
// Sequencer: takes input words, writes the vertex table, runs the fan
// search and the two angle tests, keeps the inside count and holds the
// result word.
// ----------------------------------------------------------------------------
module cpt_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	cpt_in_if.sink                         in_ch,
	cpt_out_if.source                      out_ch,
	input  logic [cpt_pkg::VC_W-1:0]       vertex_count,
	input  logic [cpt_pkg::TALLY_W-1:0]    needed_inside,
	output cpt_pkg::mem_wr_t               mem_wr,
	output cpt_pkg::addr_t                 mem_raddr,
	input  cpt_pkg::vertex_t               mem_rdata,
	output cpt_pkg::xreq_t                 xreq,
	input  cpt_pkg::xrsp_t                 xrsp
);

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_WAIT0  = 10'b0000000010,
		ST_SEARCH = 10'b0000000100,
		ST_MIDW   = 10'b0000001000,
		ST_XWAIT  = 10'b0000010000,
		ST_GETB   = 10'b0000100000,
		ST_GETC   = 10'b0001000000,
		ST_TRI    = 10'b0010000000,
		ST_TWAIT  = 10'b0100000000,
		ST_FIN    = 10'b1000000000
	} state_t;

	state_t                          state_q;
	cpt_pkg::addr_t                  lo_q, hi_q, mid_q;
	logic [cpt_pkg::STEP_W-1:0]      k_q;
	cpt_pkg::sign_t                  sg_q [cpt_pkg::TRI_STEPS];
	logic [cpt_pkg::TALLY_W-1:0]     tally_q;
	logic                            out_valid_q;
	logic                            out_inside_q;
	logic [cpt_pkg::TALLY_W-1:0]     out_count_q;
	logic                            out_enough_q;
	cpt_pkg::coord_t                 px_q, py_q, ox_q, oy_q, bx_q, by_q, cx_q, cy_q;

	logic                            in_fire;
	logic                            fin_go;
	logic                            is_in;
	logic [cpt_pkg::TALLY_W-1:0]     tally_next;
	logic [cpt_pkg::VC_W-1:0]        n_clamped;
	logic [cpt_pkg::ADDR_W:0]        mid_sum;
	cpt_pkg::addr_t                  mid_next;
	cpt_pkg::diff_t                  p1x, p1y, a1x, a1y, b1x, b1y;
	cpt_pkg::diff_t                  p2x, p2y, a2x, a2y, b2x, b2y;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign fin_go      = !out_valid_q || out_ch.ready;

	assign mem_wr.we   = in_fire && (in_ch.op == cpt_pkg::OP_LOAD)
		&& (32'(in_ch.vertex_index) < cpt_pkg::MAX_VERTICES);
	assign mem_wr.addr = cpt_pkg::ADDR_W'(in_ch.vertex_index);
	assign mem_wr.data = '{x: in_ch.coord_x, y: in_ch.coord_y};

	always_comb begin
		if (vertex_count < cpt_pkg::VC_W'(cpt_pkg::MIN_VERTICES)) begin
			n_clamped = cpt_pkg::VC_W'(cpt_pkg::MIN_VERTICES);
		end else if (32'(vertex_count) > cpt_pkg::MAX_VERTICES) begin
			n_clamped = cpt_pkg::VC_W'(cpt_pkg::MAX_VERTICES);
		end else begin
			n_clamped = vertex_count;
		end
	end

	always_comb begin
		mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
		mid_next = mid_sum[cpt_pkg::ADDR_W:1];
		case (state_q)
			ST_SEARCH: mem_raddr = (lo_q == hi_q) ? lo_q : mid_next;
			ST_GETB:   mem_raddr = lo_q - cpt_pkg::addr_t'(1);
			default:   mem_raddr = '0;
		endcase
	end

	// Triangle corners: o is vertex 0, b the found vertex, c the one before it.
	always_comb begin
		p1x = cpt_pkg::coord_diff(px_q, cx_q);
		p1y = cpt_pkg::coord_diff(py_q, cy_q);
		a1x = cpt_pkg::coord_diff(ox_q, cx_q);
		a1y = cpt_pkg::coord_diff(oy_q, cy_q);
		b1x = cpt_pkg::coord_diff(bx_q, cx_q);
		b1y = cpt_pkg::coord_diff(by_q, cy_q);
		p2x = cpt_pkg::coord_diff(px_q, ox_q);
		p2y = cpt_pkg::coord_diff(py_q, oy_q);
		a2x = cpt_pkg::coord_diff(bx_q, ox_q);
		a2y = cpt_pkg::coord_diff(by_q, oy_q);
		b2x = cpt_pkg::coord_diff(cx_q, ox_q);
		b2y = cpt_pkg::coord_diff(cy_q, oy_q);
	end

	always_comb begin
		xreq.start = (state_q == ST_MIDW) || (state_q == ST_TRI);
		xreq.ax = '0;
		xreq.ay = '0;
		xreq.bx = '0;
		xreq.by = '0;
		case (state_q)
			ST_MIDW: begin
				xreq.ax = p2x;
				xreq.ay = p2y;
				xreq.bx = cpt_pkg::coord_diff(mem_rdata.x, ox_q);
				xreq.by = cpt_pkg::coord_diff(mem_rdata.y, oy_q);
			end
			ST_TRI: begin
				case (k_q)
					3'd0: begin
						xreq.ax = b1x; xreq.ay = b1y; xreq.bx = a1x; xreq.by = a1y;
					end
					3'd1: begin
						xreq.ax = p1x; xreq.ay = p1y; xreq.bx = a1x; xreq.by = a1y;
					end
					3'd2: begin
						xreq.ax = p1x; xreq.ay = p1y; xreq.bx = b1x; xreq.by = b1y;
					end
					3'd3: begin
						xreq.ax = b2x; xreq.ay = b2y; xreq.bx = a2x; xreq.by = a2y;
					end
					3'd4: begin
						xreq.ax = p2x; xreq.ay = p2y; xreq.bx = a2x; xreq.by = a2y;
					end
					3'd5: begin
						xreq.ax = p2x; xreq.ay = p2y; xreq.bx = b2x; xreq.by = b2y;
					end
					default: begin
						xreq.ax = '0;
					end
				endcase
			end
			default: begin
				xreq.ax = '0;
			end
		endcase
	end

	always_comb begin
		is_in = cpt_pkg::sign_agree(sg_q[0], sg_q[1])
			&& cpt_pkg::sign_agree(cpt_pkg::sign_flip(sg_q[0]), sg_q[2])
			&& cpt_pkg::sign_agree(sg_q[3], sg_q[4])
			&& cpt_pkg::sign_agree(cpt_pkg::sign_flip(sg_q[3]), sg_q[5]);
		if (is_in && (tally_q != cpt_pkg::TALLY_MAX)) begin
			tally_next = tally_q + cpt_pkg::TALLY_W'(1);
		end else begin
			tally_next = tally_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tally_q     <= '0;
			out_valid_q <= 1'b0;
			lo_q        <= '0;
			hi_q        <= '0;
			k_q         <= '0;
		end else begin
			if (out_valid_q && out_ch.ready && !(state_q == ST_FIN && fin_go)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (in_ch.op)
							cpt_pkg::OP_QUERY: begin
								lo_q    <= cpt_pkg::addr_t'(2);
								hi_q    <= cpt_pkg::ADDR_W'(n_clamped - cpt_pkg::VC_W'(1));
								state_q <= ST_WAIT0;
							end
							cpt_pkg::OP_CLEAR: tally_q <= '0;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_WAIT0: state_q <= ST_SEARCH;
				ST_SEARCH: begin
					if (lo_q == hi_q) begin
						state_q <= ST_GETB;
					end else begin
						state_q <= ST_MIDW;
					end
				end
				ST_MIDW: state_q <= ST_XWAIT;
				ST_XWAIT: begin
					if (xrsp.done) begin
						if (xrsp.sgn == cpt_pkg::SG_NEG) begin
							lo_q <= mid_q + cpt_pkg::addr_t'(1);
						end else begin
							hi_q <= mid_q;
						end
						state_q <= ST_SEARCH;
					end
				end
				ST_GETB: state_q <= ST_GETC;
				ST_GETC: begin
					k_q     <= '0;
					state_q <= ST_TRI;
				end
				ST_TRI: state_q <= ST_TWAIT;
				ST_TWAIT: begin
					if (xrsp.done) begin
						if (k_q == cpt_pkg::STEP_W'(cpt_pkg::TRI_STEPS - 1)) begin
							state_q <= ST_FIN;
						end else begin
							k_q     <= k_q + cpt_pkg::STEP_W'(1);
							state_q <= ST_TRI;
						end
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						tally_q     <= tally_next;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			px_q <= in_ch.coord_x;
			py_q <= in_ch.coord_y;
		end
		if (state_q == ST_WAIT0) begin
			ox_q <= mem_rdata.x;
			oy_q <= mem_rdata.y;
		end
		if (state_q == ST_SEARCH) begin
			mid_q <= mid_next;
		end
		if (state_q == ST_GETB) begin
			bx_q <= mem_rdata.x;
			by_q <= mem_rdata.y;
		end
		if (state_q == ST_GETC) begin
			cx_q <= mem_rdata.x;
			cy_q <= mem_rdata.y;
		end
		if (state_q == ST_TWAIT && xrsp.done) begin
			sg_q[k_q] <= xrsp.sgn;
		end
		if (state_q == ST_FIN && fin_go) begin
			out_inside_q <= is_in;
			out_count_q  <= tally_next;
			out_enough_q <= (tally_next >= needed_inside);
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.is_inside    = out_inside_q;
	assign out_ch.inside_count = out_count_q;
	assign out_ch.enough       = out_enough_q;

	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		xrsp.done |-> (state_q == ST_XWAIT || state_q == ST_TWAIT))
		else $error("Cross product finished while no step was waiting for it.");

	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (lo_q >= cpt_pkg::addr_t'(2) && lo_q <= hi_q))
		else $error("Fan search bounds crossed.");

	a_fin_posts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && fin_go) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("Finished query did not post its result word.");

	a_tally_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && fin_go) |=>
		(tally_q == $past(tally_q) || tally_q == $past(tally_q) + cpt_pkg::TALLY_W'(1)))
		else $error("Inside count moved by more than one.");

endmodule

@@ rtl/convex_polygon_point_test_top.sv @@
// ----------------------------------------------------------------------------
// convex_polygon_point_test_top
// Point in convex polygon test with a saturating count of inside points.
//
// Input words arrive on in_ch: op selects load vertex, query point or clear
// count. A load writes vertex_index and a clear zeroes the count; neither
// gives a result word. A query searches the fan around vertex 0 and runs
// the two angle tests, then posts its result word on out_ch. Each search
// step and each of the six angle products needs one cross product, and all
// of them share one multiplier beside the single read port of the vertex
// table. One query is worked on at a time.
// The result register holds a finished word while out_ch stalls; the block
// takes further loads and clears meanwhile and holds a next query at its
// end until the register frees. The config port sets vertex_count and
// needed_inside; the user must write it only while the block is idle, as
// the block itself does not enforce this.
// Reset sets vertex_count to 3, needed_inside and the count to 0; the
// vertex table is not cleared and must be loaded before queries.
// ----------------------------------------------------------------------------
module convex_polygon_point_test_top (
	input  logic                               clk,
	input  logic                               arst_n,
	cpt_in_if.sink                             in_ch,
	cpt_out_if.source                          out_ch,
	input  logic                               cfg_we,
	input  logic [cpt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cpt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	logic [cpt_pkg::VC_W-1:0]    vertex_count_q;
	logic [cpt_pkg::TALLY_W-1:0] needed_inside_q;
	cpt_pkg::mem_wr_t            mem_wr;
	cpt_pkg::addr_t              mem_raddr;
	cpt_pkg::vertex_t            mem_rdata;
	cpt_pkg::xreq_t              xreq;
	cpt_pkg::xrsp_t              xrsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q  <= cpt_pkg::VC_W'(cpt_pkg::MIN_VERTICES);
			needed_inside_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				cpt_pkg::REG_VERTEX_COUNT:  vertex_count_q  <= cfg_wdata[cpt_pkg::VC_W-1:0];
				cpt_pkg::REG_NEEDED_INSIDE: needed_inside_q <= cfg_wdata[cpt_pkg::TALLY_W-1:0];
				default: needed_inside_q <= needed_inside_q;
			endcase
		end
	end

	cpt_vertex_mem u_mem (
		.clk   (clk),
		.wr    (mem_wr),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	cpt_cross_unit u_cross (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (xreq),
		.rsp    (xrsp)
	);

	cpt_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_ch         (in_ch),
		.out_ch        (out_ch),
		.vertex_count  (vertex_count_q),
		.needed_inside (needed_inside_q),
		.mem_wr        (mem_wr),
		.mem_raddr     (mem_raddr),
		.mem_rdata     (mem_rdata),
		.xreq          (xreq),
		.xrsp          (xrsp)
	);

endmodule

@@ verif/cpt_result_checker.sv @@
// ----------------------------------------------------------------------------
// cpt_result_checker
// Watches the word and result channels and the config port of the convex
// polygon point test block. It keeps its own vertex table, count and config,
// predicts the result of every accepted query and compares each accepted
// result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module cpt_result_checker
	import cpt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	cpt_in_if                     in_ch,
	cpt_out_if                    out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    mismatches,
	output int                    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic               is_inside;
		logic [TALLY_W-1:0] inside_count;
		logic               enough;
	} verdict_t;

	verdict_t           verdict_q[$];
	longint             vert_x[MAX_VERTICES];
	longint             vert_y[MAX_VERTICES];
	logic [VC_W-1:0]    vc_reg;
	logic [TALLY_W-1:0] needed_reg;
	logic [TALLY_W-1:0] tally;

	function automatic int cross_dir(longint ax, longint ay, longint bx, longint by);
		longint p;
		longint q;
		p = ax * by;
		q = bx * ay;
		return (p > q) ? 1 : ((p < q) ? -1 : 0);
	endfunction

	function automatic bit in_angle(longint px, longint py, longint ax, longint ay,
			longint bx, longint by);
		return (cross_dir(bx, by, ax, ay) * cross_dir(px, py, ax, ay) >= 0) &&
			(cross_dir(ax, ay, bx, by) * cross_dir(px, py, bx, by) >= 0);
	endfunction

	function automatic bit point_in_polygon(longint px, longint py);
		int     n;
		int     lo;
		int     hi;
		int     mid;
		longint ox;
		longint oy;
		longint bx;
		longint by;
		longint cx;
		longint cy;
		n = int'(vc_reg);
		if (n < MIN_VERTICES) n = MIN_VERTICES;
		if (n > MAX_VERTICES) n = MAX_VERTICES;
		ox = vert_x[0];
		oy = vert_y[0];
		lo = 2;
		hi = n - 1;
		while (lo != hi) begin
			mid = (lo + hi) >> 1;
			if (cross_dir(px - ox, py - oy, vert_x[mid] - ox, vert_y[mid] - oy) == -1)
				lo = mid + 1;
			else
				hi = mid;
		end
		bx = vert_x[lo];
		by = vert_y[lo];
		cx = vert_x[lo-1];
		cy = vert_y[lo-1];
		return in_angle(px - cx, py - cy, ox - cx, oy - cy, bx - cx, by - cy) &&
			in_angle(px - ox, py - oy, bx - ox, by - oy, cx - ox, cy - oy);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		verdict_t want;
		bit       ins;
		if (!arst_n) begin
			verdict_q.delete();
			tally       = '0;
			vc_reg      = VC_W'(MIN_VERTICES);
			needed_reg  = '0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_VERTEX_COUNT:  vc_reg = cfg_wdata[VC_W-1:0];
					REG_NEEDED_INSIDE: needed_reg = cfg_wdata[TALLY_W-1:0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready) begin
				case (in_ch.op)
					OP_LOAD: begin
						vert_x[in_ch.vertex_index] = longint'(in_ch.coord_x);
						vert_y[in_ch.vertex_index] = longint'(in_ch.coord_y);
					end
					OP_CLEAR: tally = '0;
					OP_QUERY: begin
						ins = point_in_polygon(longint'(in_ch.coord_x), longint'(in_ch.coord_y));
						if (ins && tally != TALLY_MAX) tally = tally + TALLY_W'(1);
						want.is_inside    = ins;
						want.inside_count = tally;
						want.enough       = (tally >= needed_reg);
						verdict_q.push_back(want);
					end
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				if (verdict_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word: inside=%0d count=%0d enough=%0d",
							out_ch.is_inside, out_ch.inside_count, out_ch.enough);
				end else begin
					want = verdict_q.pop_front();
					if (out_ch.is_inside !== want.is_inside ||
							out_ch.inside_count !== want.inside_count ||
							out_ch.enough !== want.enough) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("result mismatch: expected inside=%0d count=%0d enough=%0d",
								want.is_inside, want.inside_count, want.enough);
							$display("                 got inside=%0d count=%0d enough=%0d",
								out_ch.is_inside, out_ch.inside_count, out_ch.enough);
						end
					end
				end
			end
			outstanding = verdict_q.size();
		end
	end

endmodule

@@ verif/tb_convex_polygon_point_test_top.sv @@
// ----------------------------------------------------------------------------
// tb_convex_polygon_point_test_top
// Loads convex polygons of many sizes, orientations and positions into the
// block and sends query points inside, outside and on the boundary, mixed
// with clears, ignored words and stray loads, under random idling on both
// channels. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_convex_polygon_point_test_top;
	timeunit 1ns;
	timeprecision 1ps;
	import cpt_pkg::*;

	localparam logic [1:0] OP_UNUSED     = 2'd3;
	localparam longint     COORD_MIN     = -(longint'(1) << 30);
	localparam longint     COORD_MAX     = (longint'(1) << 30) - 1;
	localparam int         SETTLE_CYCLES = 120;
	localparam int         RANDOM_WORDS  = 1600;
	localparam real        TWO_PI        = 6.283185307179586;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    mismatches;
	int                    outstanding;
	bit                    calm;
	int                    words_sent;
	longint                poly_x[MAX_VERTICES];
	longint                poly_y[MAX_VERTICES];
	int                    poly_n;
	real                   ctr_x;
	real                   ctr_y;
	real                   rad_x;
	real                   rad_y;

	cpt_in_if  in_ch();
	cpt_out_if out_ch();

	convex_polygon_point_test_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	cpt_result_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("convex_polygon_point_test_top test failed");
		$finish;
	end

	function automatic real rand_unit();
		return real'($urandom()) / 4294967296.0;
	endfunction

	function automatic longint clamp_coord(longint v);
		if (v < COORD_MIN) return COORD_MIN;
		if (v > COORD_MAX) return COORD_MAX;
		return v;
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [TALLY_W-1:0] pick_threshold();
		case ($urandom_range(0, 4))
			0:       return '0;
			1:       return TALLY_MAX;
			2:       return $urandom_range(0, 8);
			3:       return $urandom_range(9, 40);
			default: return $urandom();
		endcase
	endfunction

	initial begin : sink_ready
		int run;
		int stall;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			run = calm ? 40 : $urandom_range(1, 20);
			repeat (run) begin
				@(negedge clk);
				out_ch.ready <= 1'b1;
			end
			stall = calm ? 0 : pick_gap();
			repeat (stall) begin
				@(negedge clk);
				out_ch.ready <= 1'b0;
			end
		end
	end

	task automatic send_word(input logic [1:0] op, input logic [IDX_W-1:0] idx,
			input longint x, input longint y);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.op           <= op;
		in_ch.vertex_index <= idx;
		in_ch.coord_x      <= coord_t'(x);
		in_ch.coord_y      <= coord_t'(y);
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
		if (op != OP_UNUSED) words_sent++;
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Bits above the register width are don't-care and get random values now and then.
	task automatic write_count(input int n);
		logic [CFG_DATA_W-1:0] v;
		v = CFG_DATA_W'(n);
		if ($urandom_range(0, 3) == 0)
			v[CFG_DATA_W-1:VC_W] = (CFG_DATA_W - VC_W)'($urandom());
		write_reg(REG_VERTEX_COUNT, v);
	endtask

	task automatic load_polygon(input int n, input bit tiny, input bit reverse);
		real r;
		real span;
		real a0;
		real ang;
		int  dir;
		int  lg;
		int  shift;
		lg    = $clog2(n);
		shift = tiny ? $urandom_range(0, 3) :
			$urandom_range((8 + 2 * lg > 29) ? 29 : 8 + 2 * lg, 29);
		r     = real'(longint'(1) << shift) * (0.5 + 0.5 * rand_unit());
		rad_x = r;
		rad_y = r * (0.4 + 0.6 * rand_unit());
		if ($urandom_range(0, 1) == 1) begin
			rad_y = rad_x;
			rad_x = r * (0.4 + 0.6 * rand_unit());
		end
		span  = real'(COORD_MAX) - 1.5 * r;
		ctr_x = (2.0 * rand_unit() - 1.0) * span;
		ctr_y = (2.0 * rand_unit() - 1.0) * span;
		a0    = TWO_PI * rand_unit();
		dir   = ($urandom_range(0, 6) == 0) ? -1 : 1;
		for (int k = 0; k < n; k++) begin
			ang = a0 + real'(dir) * TWO_PI * real'(k) / real'(n);
			poly_x[k] = clamp_coord(longint'(ctr_x + rad_x * $cos(ang)));
			poly_y[k] = clamp_coord(longint'(ctr_y + rad_y * $sin(ang)));
		end
		poly_n = n;
		for (int k = 0; k < n; k++) begin
			if (reverse)
				send_word(OP_LOAD, IDX_W'(n - 1 - k), poly_x[n-1-k], poly_y[n-1-k]);
			else
				send_word(OP_LOAD, IDX_W'(k), poly_x[k], poly_y[k]);
		end
	endtask

	task automatic send_query();
		int     sel;
		int     k;
		int     j;
		longint den;
		longint num;
		longint qx;
		longint qy;
		sel = $urandom_range(0, 99);
		k   = $urandom_range(0, poly_n - 1);
		j   = (k + 1) % poly_n;
		if (sel < 45) begin
			qx = clamp_coord(longint'(ctr_x + (2.0 * rand_unit() - 1.0) * 1.3 * rad_x));
			qy = clamp_coord(longint'(ctr_y + (2.0 * rand_unit() - 1.0) * 1.3 * rad_y));
		end else if (sel < 60) begin
			qx = poly_x[k];
			qy = poly_y[k];
		end else if (sel < 75) begin
			den = longint'(1) << $urandom_range(1, 4);
			num = $urandom_range(0, int'(den));
			qx  = poly_x[k] + (poly_x[j] - poly_x[k]) * num / den;
			qy  = poly_y[k] + (poly_y[j] - poly_y[k]) * num / den;
		end else if (sel < 85) begin
			qx = clamp_coord(poly_x[k] + longint'($urandom_range(0, 6)) - 3);
			qy = clamp_coord(poly_y[k] + longint'($urandom_range(0, 6)) - 3);
		end else if (sel < 95) begin
			qx = longint'(coord_t'($urandom()));
			qy = longint'(coord_t'($urandom()));
		end else begin
			qx = clamp_coord(longint'(ctr_x));
			qy = clamp_coord(longint'(ctr_y));
		end
		send_word(OP_QUERY, IDX_W'($urandom_range(0, 1023)), qx, qy);
	endtask

	task automatic run_phase(input int n, input int words, input bit tiny, input int count_val);
		int sel;
		int k;
		settle();
		write_count(count_val);
		write_reg(REG_NEEDED_INSIDE, pick_threshold());
		calm = ($urandom_range(0, 5) == 0);
		load_polygon(n, tiny, $urandom_range(0, 3) == 0);
		repeat (words) begin
			sel = $urandom_range(0, 99);
			k   = $urandom_range(0, poly_n - 1);
			if (sel < 82)
				send_query();
			else if (sel < 87)
				send_word(OP_CLEAR, IDX_W'($urandom()), longint'(coord_t'($urandom())),
					longint'(coord_t'($urandom())));
			else if (sel < 92)
				send_word(OP_UNUSED, IDX_W'($urandom()), longint'(coord_t'($urandom())),
					longint'(coord_t'($urandom())));
			else if (sel < 97)
				send_word(OP_LOAD, IDX_W'(k), poly_x[k], poly_y[k]);
			else
				send_word(OP_LOAD, IDX_W'($urandom()), longint'(coord_t'($urandom())),
					longint'(coord_t'($urandom())));
		end
	endtask

	initial begin : stimulus
		int n;
		int sel;
		int count_val;
		in_ch.valid        = 1'b0;
		in_ch.op           = OP_LOAD;
		in_ch.vertex_index = '0;
		in_ch.coord_x      = '0;
		in_ch.coord_y      = '0;
		cfg_we             = 1'b0;
		cfg_index          = REG_VERTEX_COUNT;
		cfg_wdata          = '0;
		arst_n             = 1'b0;
		calm               = 1'b0;
		words_sent         = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset vertex count, a triangle spanning the whole coordinate range.
		write_reg(REG_NEEDED_INSIDE, 32'd2);
		poly_x[0] = COORD_MIN; poly_y[0] = COORD_MIN;
		poly_x[1] = COORD_MAX; poly_y[1] = COORD_MIN;
		poly_x[2] = COORD_MIN; poly_y[2] = COORD_MAX;
		poly_n = 3;
		ctr_x  = -3.0e8; ctr_y = -3.0e8; rad_x = 7.0e8; rad_y = 7.0e8;
		for (int k = 0; k < 3; k++) send_word(OP_LOAD, IDX_W'(k), poly_x[k], poly_y[k]);
		for (int k = 0; k < 3; k++) send_word(OP_QUERY, '0, poly_x[k], poly_y[k]);
		send_word(OP_QUERY, '1, -1, COORD_MIN);
		send_word(OP_QUERY, '0, COORD_MIN, 0);
		send_word(OP_QUERY, '0, -1, 0);
		send_word(OP_QUERY, '0, 0, 0);
		send_word(OP_QUERY, '0, COORD_MAX, COORD_MAX);
		send_word(OP_QUERY, '0, COORD_MIN + 1, COORD_MIN + 1);
		send_word(OP_UNUSED, '1, -1, -1);
		send_word(OP_CLEAR, '0, 0, 0);
		send_word(OP_QUERY, '0, COORD_MIN + 5, COORD_MIN + 7);

		settle();
		write_reg(REG_VERTEX_COUNT, 32'd0);
		write_reg(REG_NEEDED_INSIDE, TALLY_MAX);
		send_word(OP_QUERY, '0, poly_x[0], poly_y[0]);
		send_word(OP_LOAD, '1, COORD_MAX, COORD_MIN);
		send_word(OP_QUERY, '0, COORD_MAX, COORD_MAX);

		// Full table, then the vertex count at and beyond its maximum.
		run_phase(MAX_VERTICES, 30, 1'b0, MAX_VERTICES);
		settle();
		write_reg(REG_VERTEX_COUNT, 32'd2047);
		repeat (12) send_query();
		settle();
		write_reg(REG_VERTEX_COUNT, 32'd1025);
		repeat (6) send_query();

		while (words_sent < RANDOM_WORDS) begin
			sel = $urandom_range(0, 99);
			if (sel < 70)
				n = $urandom_range(3, 12);
			else if (sel < 90)
				n = $urandom_range(13, 64);
			else
				n = $urandom_range(65, 300);
			count_val = (n == 3) ? $urandom_range(0, 3) : n;
			run_phase(n, $urandom_range(10, 40), $urandom_range(0, 19) == 0, count_val);
		end

		calm = 1'b0;
		settle();
		if (mismatches == 0 && outstanding == 0)
			$display("convex_polygon_point_test_top test passed");
		else
			$display("convex_polygon_point_test_top test failed");
		$finish;
	end

endmodule

@@ files.f @@
rtl/cpt_pkg.sv
rtl/cpt_stream_if.sv
rtl/cpt_vertex_mem.sv
rtl/cpt_cross_unit.sv
rtl/cpt_ctrl.sv
rtl/convex_polygon_point_test_top.sv
verif/cpt_result_checker.sv
verif/tb_convex_polygon_point_test_top.sv
